>>> hdl/cfa_pkg.sv
`default_nettype none
package cfa_pkg;

   // operation codes
   localparam logic [3:0] FN_MUL = 4'd0;
   localparam logic [3:0] FN_DIV = 4'd1;
   localparam logic [3:0] FN_MOD = 4'd2;
   localparam logic [3:0] FN_ADD = 4'd3;
   localparam logic [3:0] FN_SUB = 4'd4;
   localparam logic [3:0] FN_SHL = 4'd5;
   localparam logic [3:0] FN_SHR = 4'd6;
   localparam logic [3:0] FN_LT  = 4'd7;
   localparam logic [3:0] FN_GT  = 4'd8;
   localparam logic [3:0] FN_LE  = 4'd9;
   localparam logic [3:0] FN_GE  = 4'd10;
   localparam logic [3:0] FN_EQ  = 4'd11;
   localparam logic [3:0] FN_NE  = 4'd12;
   localparam logic [3:0] FN_AND = 4'd13;
   localparam logic [3:0] FN_OR  = 4'd14;
   localparam logic [3:0] FN_XOR = 4'd15;

   // per-request control that travels down the pipe
   typedef struct packed {
      logic [3:0] func;
      logic       uns;
      logic       ptr;
      logic [3:0] size;
      logic       dz;
      logic       neg_q;
      logic       neg_r;
   } cfa_ctl_type;

endpackage
`default_nettype wire

>>> hdl/cfa_front.sv
`default_nettype none
module cfa_front import cfa_pkg::*; #(
   parameter int W = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire cfa_ctl_type   in_ctl,
   input  wire logic [W-1:0]  in_a,
   input  wire logic [W-1:0]  in_b,
   output logic               out_valid,
   output cfa_ctl_type        out_ctl,
   output logic [W-1:0]       out_val,
   output logic [W-1:0]       out_p0,
   output logic [W/2-1:0]     out_p1,
   output logic [W/2-1:0]     out_p2,
   output logic [W-1:0]       out_ma,
   output logic [W-1:0]       out_mb
);
   localparam int H = W / 2;

   logic               valid_ff;
   cfa_ctl_type        ctl_ff, ctl_in;
   logic [W-1:0]       val_ff, val_in;
   logic [W-1:0]       p0_ff, p0_in;
   logic [H-1:0]       p1_ff, p1_in, p2_ff, p2_in;
   logic [W-1:0]       ma_ff, ma_in, mb_ff, mb_in;
   logic [W-1:0]       p1_full, p2_full;
   logic               na, nb, lt, gt, eq;

   always_comb begin
      na = !in_ctl.uns && in_a[W-1];
      nb = !in_ctl.uns && in_b[W-1];
      eq = (in_a == in_b);
      lt = in_ctl.uns ? (in_a < in_b) : ($signed(in_a) < $signed(in_b));
      gt = !lt && !eq;
      ma_in = na ? (~in_a + 1'b1) : in_a;
      mb_in = nb ? (~in_b + 1'b1) : in_b;
      // low word of the product from three half-width products
      p0_in   = in_a[H-1:0] * in_b[H-1:0];
      p1_full = in_a[W-1:H] * in_b[H-1:0];
      p2_full = in_a[H-1:0] * in_b[W-1:H];
      p1_in   = p1_full[H-1:0];
      p2_in   = p2_full[H-1:0];
      ctl_in       = in_ctl;
      ctl_in.dz    = (in_b == '0) && (in_ctl.func == FN_DIV || in_ctl.func == FN_MOD);
      ctl_in.neg_q = na ^ nb;
      ctl_in.neg_r = na;
      unique case (in_ctl.func)
         FN_ADD:  val_in = in_a + in_b;
         FN_SUB:  val_in = in_a - in_b;
         FN_SHL:  val_in = in_a << in_b;
         FN_SHR:  val_in = in_ctl.uns ? (in_a >> in_b) : W'($signed(in_a) >>> in_b);
         FN_LT:   val_in = {{(W-1){1'b0}}, lt};
         FN_GT:   val_in = {{(W-1){1'b0}}, gt};
         FN_LE:   val_in = {{(W-1){1'b0}}, !gt};
         FN_GE:   val_in = {{(W-1){1'b0}}, !lt};
         FN_EQ:   val_in = {{(W-1){1'b0}}, eq};
         FN_NE:   val_in = {{(W-1){1'b0}}, !eq};
         FN_AND:  val_in = in_a & in_b;
         FN_OR:   val_in = in_a | in_b;
         FN_XOR:  val_in = in_a ^ in_b;
         default: val_in = in_a;  // mul, div, mod: left operand for the zero divisor case
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         ctl_ff <= ctl_in;
         val_ff <= val_in;
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_val   = val_ff;
   assign out_p0    = p0_ff;
   assign out_p1    = p1_ff;
   assign out_p2    = p2_ff;
   assign out_ma    = ma_ff;
   assign out_mb    = mb_ff;
endmodule
`default_nettype wire

>>> hdl/cfa_div_step.sv
`default_nettype none
module cfa_div_step import cfa_pkg::*; #(
   parameter int W  = 64,
   parameter int SB = 192
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire cfa_ctl_type   in_ctl,
   input  wire logic [W-1:0]  in_rem,
   input  wire logic [W-1:0]  in_num,
   input  wire logic [W-1:0]  in_den,
   input  wire logic [SB-1:0] in_side,
   output logic               out_valid,
   output cfa_ctl_type        out_ctl,
   output logic [W-1:0]       out_rem,
   output logic [W-1:0]       out_num,
   output logic [W-1:0]       out_den,
   output logic [SB-1:0]      out_side
);
   logic              valid_ff;
   cfa_ctl_type       ctl_ff;
   logic [W-1:0]      rem_ff, rem_in, num_ff, num_in, den_ff;
   logic [SB-1:0]     side_ff;
   logic [W:0]        trial, diff;
   logic              fits;

   // one restoring step: the quotient bit shifts in as the dividend shifts out
   always_comb begin
      trial  = {in_rem, in_num[W-1]};
      diff   = trial - {1'b0, in_den};
      fits   = !diff[W];
      rem_in = fits ? diff[W-1:0] : trial[W-1:0];
      num_in = {in_num[W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         ctl_ff  <= in_ctl;
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

>>> hdl/const_fold_alu_top.sv
`default_nettype none
// constant-folding integer alu: one request per cycle in, one response per request out,
// in order. the pipe holds 8*LONG_BYTES + 4 register stages (input register, operand
// stage, one restoring divider step per word bit, result select, truncation); that
// depth is set by the divider, which every request passes through so that all operations
// share one latency. the word is 8*LONG_BYTES bits; the operation result is cut to
// size_bytes bytes, masked when unsigned and not a pointer, sign-extended otherwise,
// with overflow flagged when the dropped bits are significant. a zero divisor passes
// the left operand and raises divide_by_zero. the whole pipe moves together and holds
// while a response waits under rsp_stall
module const_fold_alu_top import cfa_pkg::*; #(
   parameter int LONG_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_func,
   input  wire logic [63:0] req_left_operand,
   input  wire logic [63:0] req_right_operand,
   input  wire logic        req_is_unsigned,
   input  wire logic        req_is_pointer,
   input  wire logic [3:0]  req_size_bytes,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_result,
   output logic             rsp_divide_by_zero,
   output logic             rsp_overflow
);
   localparam int W  = 8 * LONG_BYTES;
   localparam int H  = W / 2;
   localparam int SB = 3 * W;

   // pipe advance: everything moves unless a response is held
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // input register
   logic          in_valid_ff;
   cfa_ctl_type   in_ctl_ff, in_ctl_in;
   logic [W-1:0]  in_a_ff, in_b_ff;

   always_comb begin
      in_ctl_in       = '0;
      in_ctl_in.func  = req_func;
      in_ctl_in.uns   = req_is_unsigned;
      in_ctl_in.ptr   = req_is_pointer;
      in_ctl_in.size  = req_size_bytes;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid;
      end
      if (en) begin
         in_ctl_ff <= in_ctl_in;
         in_a_ff   <= req_left_operand[W-1:0];
         in_b_ff   <= req_right_operand[W-1:0];
      end
   end

   // operand stage: simple ops, partial products, divider magnitudes
   logic          fr_valid;
   cfa_ctl_type   fr_ctl;
   logic [W-1:0]  fr_val, fr_p0, fr_ma, fr_mb;
   logic [H-1:0]  fr_p1, fr_p2;

   cfa_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid_ff),
      .in_ctl    (in_ctl_ff),
      .in_a      (in_a_ff),
      .in_b      (in_b_ff),
      .out_valid (fr_valid),
      .out_ctl   (fr_ctl),
      .out_val   (fr_val),
      .out_p0    (fr_p0),
      .out_p1    (fr_p1),
      .out_p2    (fr_p2),
      .out_ma    (fr_ma),
      .out_mb    (fr_mb)
   );

   // divider chain, one quotient bit per stage; other results ride along as sideband
   logic          dv_valid [0:W];
   cfa_ctl_type   dv_ctl   [0:W];
   logic [W-1:0]  dv_rem   [0:W];
   logic [W-1:0]  dv_num   [0:W];
   logic [W-1:0]  dv_den   [0:W];
   logic [SB-1:0] dv_side  [0:W];

   assign dv_valid[0] = fr_valid;
   assign dv_ctl[0]   = fr_ctl;
   assign dv_rem[0]   = '0;
   assign dv_num[0]   = fr_ma;
   assign dv_den[0]   = fr_mb;
   assign dv_side[0]  = {fr_val, fr_p0, fr_p1, fr_p2};

   for (genvar i = 0; i < W; i++) begin : g_div
      cfa_div_step #(.W(W), .SB(SB)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[i]),
         .in_ctl    (dv_ctl[i]),
         .in_rem    (dv_rem[i]),
         .in_num    (dv_num[i]),
         .in_den    (dv_den[i]),
         .in_side   (dv_side[i]),
         .out_valid (dv_valid[i+1]),
         .out_ctl   (dv_ctl[i+1]),
         .out_rem   (dv_rem[i+1]),
         .out_num   (dv_num[i+1]),
         .out_den   (dv_den[i+1]),
         .out_side  (dv_side[i+1])
      );
   end

   // result select: sign fix of quotient and remainder, product sum
   logic          sel_valid_ff;
   cfa_ctl_type   sel_ctl_ff;
   logic [W-1:0]  sel_v_ff, sel_v_in;
   logic [W-1:0]  last_val, last_p0, quo, rmd;
   logic [H-1:0]  last_p1, last_p2, cross_sum;

   always_comb begin
      {last_val, last_p0, last_p1, last_p2} = dv_side[W];
      quo       = dv_num[W];
      rmd       = dv_rem[W];
      cross_sum = last_p1 + last_p2;
      if (dv_ctl[W].func == FN_MUL) begin
         sel_v_in = last_p0 + {cross_sum, {H{1'b0}}};
      end else if (dv_ctl[W].func == FN_DIV && !dv_ctl[W].dz) begin
         sel_v_in = dv_ctl[W].neg_q ? (~quo + 1'b1) : quo;
      end else if (dv_ctl[W].func == FN_MOD && !dv_ctl[W].dz) begin
         sel_v_in = dv_ctl[W].neg_r ? (~rmd + 1'b1) : rmd;
      end else begin
         sel_v_in = last_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (en) begin
         sel_valid_ff <= dv_valid[W];
      end
      if (en) begin
         sel_ctl_ff <= dv_ctl[W];
         sel_v_ff   <= sel_v_in;
      end
   end

   // truncation to the type size and response register
   logic          rsp_valid_ff;
   logic [63:0]   rsp_result_ff, rsp_result_in;
   logic          rsp_dz_ff, rsp_ovf_ff, rsp_ovf_in;
   logic [3:0]    sz;
   logic [6:0]    tbits;
   logic [5:0]    top_bit;
   logic [63:0]   v64, tmask, wmask, hi, rest;
   logic          sext;

   always_comb begin
      if (sel_ctl_ff.size == 4'd0) begin
         sz = 4'd1;
      end else if (sel_ctl_ff.size > 4'(LONG_BYTES)) begin
         sz = 4'(LONG_BYTES);
      end else begin
         sz = sel_ctl_ff.size;
      end
      tbits   = {sz, 3'b000};
      top_bit = 6'(tbits - 7'd1);
      v64     = 64'(sel_v_ff);
      tmask   = ~64'd0 >> (7'd64 - tbits);
      wmask   = 64'({W{1'b1}});
      hi      = wmask & ~tmask;
      rest    = v64 & hi;
      sext    = !sel_ctl_ff.uns || sel_ctl_ff.ptr;
      if (sext) begin
         rsp_ovf_in    = (rest != '0) && (rest != hi);
         rsp_result_in = (v64 & tmask) | (v64[top_bit] ? ~tmask : 64'd0);
      end else begin
         rsp_ovf_in    = (rest != '0);
         rsp_result_in = v64 & tmask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sel_valid_ff;
      end
      if (en) begin
         rsp_result_ff <= rsp_result_in;
         rsp_dz_ff     <= sel_ctl_ff.dz;
         rsp_ovf_ff    <= rsp_ovf_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;
   assign rsp_overflow       = rsp_ovf_ff;

   // accepted request reaches the input register
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> in_valid_ff)
      else $error("accepted request lost at input register");

   // zero divisor flag only on divide or modulo
   a_dz_op: assert property (@(posedge clock) disable iff (reset)
      (sel_valid_ff && sel_ctl_ff.dz) |-> (sel_ctl_ff.func == FN_DIV || sel_ctl_ff.func == FN_MOD))
      else $error("divide_by_zero on non-divide op");

   // held pipe keeps the divider output in place
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(dv_valid[W]) && $stable(sel_valid_ff)))
      else $error("pipe moved while response held");

   // unsigned truncation without overflow drops no set bit
   a_trunc: assert property (@(posedge clock) disable iff (reset)
      (sel_valid_ff && sel_ctl_ff.uns && !sel_ctl_ff.ptr && !rsp_ovf_in)
         |-> (rsp_result_in == v64))
      else $error("unsigned truncation lost bits without overflow");
endmodule
`default_nettype wire

>>> sim/tb_const_fold_alu_top.sv
`timescale 1ns / 1ps
module tb_const_fold_alu_top;
   import cfa_pkg::*;

   localparam int LONG_BYTES = 8;
   localparam int WBITS      = 8 * LONG_BYTES;
   // pipe depth from acceptance to the response register
   localparam int PIPE_DEPTH = WBITS + 4;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [3:0]  func;
      logic [63:0] lhs;
      logic [63:0] rhs;
      logic        uns;
      logic        ptr;
      logic [3:0]  size;
   } alu_req_type;

   typedef struct {
      logic [63:0] result;
      logic        dz;
      logic        ovf;
   } alu_rsp_type;

   // one row of the directed table; has_typed marks a hand-typed result
   typedef struct {
      alu_req_type req;
      logic        has_typed;
      alu_rsp_type typed;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_func = FN_MUL;
   logic [63:0] req_left_operand = '0;
   logic [63:0] req_right_operand = '0;
   logic        req_is_unsigned = 1'b0;
   logic        req_is_pointer = 1'b0;
   logic [3:0]  req_size_bytes = 4'd8;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [63:0] rsp_result;
   logic        rsp_divide_by_zero;
   logic        rsp_overflow;

   const_fold_alu_top #(.LONG_BYTES(LONG_BYTES)) dut (.*);

   always #5 clock = ~clock;

   alu_rsp_type pending_rsp[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_off = 1'b0;
   bit          done_sending = 1'b0;
   bit          timed_out = 1'b0;

   // word masks for the truncation width
   function automatic logic [63:0] width_mask(input int bits);
      return (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
   endfunction

   function automatic logic [63:0] sign_extend(input logic [63:0] v, input int bits);
      logic [63:0] m;
      m = 64'd1 << (bits - 1);
      return ((v & width_mask(bits)) ^ m) - m;
   endfunction

   // golden alu: operate on the machine word, then cut to the type size
   function automatic alu_rsp_type fold_constant(input alu_req_type r);
      alu_rsp_type o;
      logic [63:0] wmask, a, b, ka, kb, v, ma, mb, tmask, hi, rest;
      logic        na, nb;
      int          tsize, tbits;
      wmask = width_mask(WBITS);
      a  = r.uns ? (r.lhs & wmask) : sign_extend(r.lhs, WBITS);
      b  = r.uns ? (r.rhs & wmask) : sign_extend(r.rhs, WBITS);
      // flip the sign bit so signed order becomes unsigned order
      ka = r.uns ? a : (a ^ (64'd1 << 63));
      kb = r.uns ? b : (b ^ (64'd1 << 63));
      o.dz = 1'b0;
      v = '0;
      case (r.func)
         FN_MUL: v = a * b;
         FN_DIV, FN_MOD: begin
            if ((r.rhs & wmask) == 0) begin
               o.dz = 1'b1;
               v = a;
            end else if (r.uns) begin
               v = (r.func == FN_DIV) ? a / b : a % b;
            end else begin
               na = a[63];
               nb = b[63];
               ma = na ? -a : a;
               mb = nb ? -b : b;
               if (r.func == FN_DIV) v = (na != nb) ? -(ma / mb) : ma / mb;
               else                  v = na ? -(ma % mb) : ma % mb;
            end
         end
         FN_ADD: v = a + b;
         FN_SUB: v = a - b;
         FN_SHL: v = ((r.rhs & wmask) >= WBITS) ? '0 : a << (r.rhs & wmask);
         FN_SHR: begin
            if (r.uns)
               v = ((r.rhs & wmask) >= WBITS) ? '0 : a >> (r.rhs & wmask);
            else if ((r.rhs & wmask) >= WBITS)
               v = $signed(a) >>> (WBITS - 1);
            else
               v = $signed(a) >>> (r.rhs & wmask);
         end
         FN_LT: v = {63'd0, ka < kb};
         FN_GT: v = {63'd0, ka > kb};
         FN_LE: v = {63'd0, ka <= kb};
         FN_GE: v = {63'd0, ka >= kb};
         FN_EQ: v = {63'd0, (r.lhs & wmask) == (r.rhs & wmask)};
         FN_NE: v = {63'd0, (r.lhs & wmask) != (r.rhs & wmask)};
         FN_AND: v = a & b;
         FN_OR:  v = a | b;
         default: v = a ^ b;
      endcase
      v &= wmask;
      // a size of zero acts as one byte, oversize clamps to the word
      tsize = (r.size == 0) ? 1 : ((r.size > LONG_BYTES) ? LONG_BYTES : int'(r.size));
      tbits = 8 * tsize;
      tmask = width_mask(tbits);
      hi    = wmask & ~tmask;
      rest  = v & hi;
      if (r.uns && !r.ptr) begin
         o.ovf    = rest != 0;
         o.result = v & tmask;
      end else begin
         o.ovf    = (rest != 0) && (rest != hi);
         o.result = sign_extend(v, tbits);
      end
      return o;
   endfunction

   function automatic alu_req_type make_req(input logic [3:0] f, input logic [63:0] l,
                                            input logic [63:0] r, input logic u,
                                            input logic p, input logic [3:0] s);
      alu_req_type q;
      q.func = f; q.lhs = l; q.rhs = r; q.uns = u; q.ptr = p; q.size = s;
      return q;
   endfunction

   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      // mix of small values, near the extremes, and fully random words
      case ($urandom_range(0, 5))
         0: w = 64'($urandom_range(0, 70));
         1: w = -64'($urandom_range(0, 70));
         2: w = {1'b1, 63'd0} + 64'($urandom_range(0, 3));
         3: w = {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 3));
         4: w = {32'd0, $urandom()} >> $urandom_range(0, 31);
         default: w = {$urandom(), $urandom()};
      endcase
      return w;
   endfunction

   function automatic alu_req_type rand_req();
      alu_req_type q;
      q.func = 4'($urandom_range(0, 15));
      q.lhs  = rand_word();
      q.rhs  = rand_word();
      if (q.func == FN_SHL || q.func == FN_SHR) begin
         if ($urandom_range(0, 3) != 0) q.rhs = 64'($urandom_range(0, 70));
      end else if ((q.func == FN_DIV || q.func == FN_MOD) && $urandom_range(0, 9) == 0) begin
         q.rhs = '0;
      end
      q.uns  = 1'($urandom_range(0, 1));
      q.ptr  = 1'($urandom_range(0, 1));
      // size field runs over its full 4 bits, including 0 and values past the word
      q.size = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 8));
      return q;
   endfunction

   // drive one request and hold it until the block takes it
   task automatic send_request(input alu_req_type q);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= q.func;
      req_left_operand  <= q.lhs;
      req_right_operand <= q.rhs;
      req_is_unsigned   <= q.uns;
      req_is_pointer    <= q.ptr;
      req_size_bytes    <= q.size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(fold_constant(q));
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic check_response(input alu_rsp_type want);
      if (rsp_result !== want.result || rsp_divide_by_zero !== want.dz ||
          rsp_overflow !== want.ovf) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: expected result=%h dz=%b ovf=%b, got result=%h dz=%b ovf=%b",
                     want.result, want.dz, want.ovf,
                     rsp_result, rsp_divide_by_zero, rsp_overflow);
      end
   endtask

   // response side: random stall, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response result=%h", rsp_result);
            end else begin
               check_response(pending_rsp.pop_front());
            end
         end
         rsp_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // long receiver hold-off, counted here so the sender keeps offering
   task automatic hold_receiver(input int cycles);
      hold_off = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_off = 1'b0;
   endtask

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("== FAIL ==");
         $finish;
      end
   end

   directed_row_type directed[$];

   task automatic add_row(input alu_req_type q, input logic typed,
                          input logic [63:0] res, input logic dz, input logic ovf);
      directed_row_type d;
      d.req = q; d.has_typed = typed;
      d.typed.result = res; d.typed.dz = dz; d.typed.ovf = ovf;
      directed.push_back(d);
   endtask

   initial begin
      alu_rsp_type want;
      // directed table: extremes, every operation, the special cases
      add_row(make_req(FN_ADD, 64'd0, 64'd0, 0, 0, 4'd8), 1, 64'd0, 0, 0);
      add_row(make_req(FN_DIV, 64'd77, 64'd0, 0, 0, 4'd8), 1, 64'd77, 1, 0);
      add_row(make_req(FN_MOD, '1, 64'd0, 1, 0, 4'd8), 1, '1, 1, 0);
      // most negative over minus one wraps
      add_row(make_req(FN_DIV, {1'b1, 63'd0}, '1, 0, 0, 4'd8), 1, {1'b1, 63'd0}, 0, 0);
      add_row(make_req(FN_MOD, {1'b1, 63'd0}, '1, 0, 0, 4'd8), 1, 64'd0, 0, 0);
      add_row(make_req(FN_DIV, -64'd7, 64'd2, 0, 0, 4'd8), 1, -64'd3, 0, 0);
      add_row(make_req(FN_MOD, -64'd7, 64'd2, 0, 0, 4'd8), 1, -64'd1, 0, 0);
      add_row(make_req(FN_MUL, '1, '1, 1, 0, 4'd8), 0, '0, 0, 0);
      add_row(make_req(FN_SUB, 64'd0, 64'd1, 1, 0, 4'd8), 1, '1, 0, 0);
      add_row(make_req(FN_SHL, 64'd1, 64'd64, 0, 0, 4'd8), 1, 64'd0, 0, 0);
      add_row(make_req(FN_SHR, '1, 64'd100, 0, 0, 4'd8), 1, '1, 0, 0);
      add_row(make_req(FN_SHR, '1, '1, 1, 0, 4'd8), 1, 64'd0, 0, 0);
      add_row(make_req(FN_SHR, {1'b1, 63'd0}, 64'd63, 1, 0, 4'd8), 1, 64'd1, 0, 0);
      add_row(make_req(FN_LT, '1, 64'd0, 0, 0, 4'd8), 1, 64'd1, 0, 0);
      add_row(make_req(FN_LT, '1, 64'd0, 1, 0, 4'd8), 1, 64'd0, 0, 0);
      add_row(make_req(FN_GT, 64'd5, 64'd3, 0, 0, 4'd1), 0, '0, 0, 0);
      add_row(make_req(FN_LE, 64'd3, 64'd3, 1, 0, 4'd2), 0, '0, 0, 0);
      add_row(make_req(FN_GE, {1'b1, 63'd0}, '1, 0, 0, 4'd4), 0, '0, 0, 0);
      add_row(make_req(FN_EQ, '1, '1, 0, 1, 4'd0), 0, '0, 0, 0);
      add_row(make_req(FN_NE, '1, 64'd0, 1, 0, 4'd15), 0, '0, 0, 0);
      add_row(make_req(FN_AND, '1, 64'hff, 1, 0, 4'd1), 1, 64'hff, 0, 0);
      // unsigned truncation that drops ones
      add_row(make_req(FN_OR, 64'h1ff, 64'd0, 1, 0, 4'd1), 1, 64'hff, 0, 1);
      // pointer forces sign extension
      add_row(make_req(FN_XOR, 64'h80, 64'd0, 1, 1, 4'd1), 1, '1 << 7, 0, 0);
      // upper word stays zero, so the sign flip into bit 31 is no overflow
      add_row(make_req(FN_ADD, 64'h7fff_ffff, 64'd1, 0, 0, 4'd4), 1,
              64'hffff_ffff_8000_0000, 0, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].has_typed) begin
            want = fold_constant(directed[i].req);
            if (want.result !== directed[i].typed.result ||
                want.dz !== directed[i].typed.dz ||
                want.ovf !== directed[i].typed.ovf) begin
               mismatch_count++;
               $display("typed row %0d disagrees with prediction", i);
            end
         end
         send_request(directed[i].req);
      end
      drain_responses();

      // idle mixes: sender-heavy, receiver-heavy, then full rate
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 51 : 0;
         recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 36 : 0;
         for (int n = 0; n < 410; n++) begin
            // fill the pipe behind a long receiver hold-off
            if (n == 100)
               fork
                  hold_receiver(3 * PIPE_DEPTH);
               join_none
            send_request(rand_req());
         end
         // sender waits for every response
         drain_responses();
      end

      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> const_fold_alu_top.f
hdl/cfa_pkg.sv
hdl/cfa_front.sv
hdl/cfa_div_step.sv
hdl/const_fold_alu_top.sv
sim/tb_const_fold_alu_top.sv
